@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Every property is sampled on clk_i and is off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a same-cycle implication.
`define OCTENC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle.
`define OCTENC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/octenc_pkg.sv @@
// ----------------------------------------------------------------------------
// octenc_pkg
// Shared constants for the octahedral normal encoder: default widths and the
// threshold register's width and reset value.
// ----------------------------------------------------------------------------
package octenc_pkg;

  // Default component and code widths.
  localparam int unsigned COMPONENT_BITS_DEF = 16;
  localparam int unsigned CODE_BITS_DEF      = 16;

  // Degenerate-length threshold register.
  localparam int unsigned        CFG_W        = 32;
  localparam logic [CFG_W-1:0]   MIN_LEN2_RST = 32'd107;

endpackage

@@ rtl/core/octahedral_normal_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// octahedral_normal_encoder_unit: octahedral encoding of fixed-point normals
// Throughput: one item per cycle unless out_ready_i holds the output; the
// divider has one stage per quotient bit and feeds a registered output stage.
// Reset clears every stage valid bit and loads min_len2_q with 107.
// ----------------------------------------------------------------------------
module octahedral_normal_encoder_unit #(
  parameter int unsigned COMPONENT_BITS = octenc_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned CODE_BITS      = octenc_pkg::CODE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [octenc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [COMPONENT_BITS-1:0] normal_x_i,
  input  logic signed [COMPONENT_BITS-1:0] normal_y_i,
  input  logic signed [COMPONENT_BITS-1:0] normal_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [CODE_BITS-1:0]             encoded_u_o,
  output logic [CODE_BITS-1:0]             encoded_v_o,
  output logic                             degenerate_o
);
  import octenc_pkg::*;

  // Degenerate-length threshold
  logic [CFG_W-1:0] min_len2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len2_q <= MIN_LEN2_RST;
    end else if (cfg_we_i) begin
      min_len2_q <= cfg_wdata_i;
    end
  end

  // Front end to divider
  logic                      fr_valid, fr_ready, fr_degen;
  logic [COMPONENT_BITS:0]   fr_sum;
  logic [COMPONENT_BITS+1:0] fr_num_u, fr_num_v;

  octenc_front #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_len2_i  (min_len2_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .x_i         (normal_x_i),
    .y_i         (normal_y_i),
    .z_i         (normal_z_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .degen_o     (fr_degen),
    .sum_o       (fr_sum),
    .num_u_o     (fr_num_u),
    .num_v_o     (fr_num_v)
  );

  // Divider to output stage
  logic                 dv_valid, dv_ready, dv_degen;
  logic [CODE_BITS+1:0] dv_quo_u, dv_quo_v;

  octenc_div #(
    .COMPONENT_BITS(COMPONENT_BITS),
    .CODE_BITS     (CODE_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .degen_i     (fr_degen),
    .sum_i       (fr_sum),
    .num_u_i     (fr_num_u),
    .num_v_i     (fr_num_v),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .degen_o     (dv_degen),
    .quo_u_o     (dv_quo_u),
    .quo_v_o     (dv_quo_v)
  );

  octenc_round #(
    .CODE_BITS(CODE_BITS)
  ) u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dv_valid),
    .in_ready_o  (dv_ready),
    .degen_i     (dv_degen),
    .quo_u_i     (dv_quo_u),
    .quo_v_i     (dv_quo_v),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_u_o    (encoded_u_o),
    .code_v_o    (encoded_v_o),
    .degen_o     (degenerate_o)
  );

endmodule

@@ rtl/core/octenc_front.sv @@
// ----------------------------------------------------------------------------
// octenc_front
// Three-stage front end: squares and magnitudes, then squared length and
// L1 sum, then the degenerate test and the octahedral numerators.
// ----------------------------------------------------------------------------
module octenc_front #(
  parameter int unsigned COMPONENT_BITS = octenc_pkg::COMPONENT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [octenc_pkg::CFG_W-1:0]       min_len2_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [COMPONENT_BITS-1:0]   x_i,
  input  logic signed [COMPONENT_BITS-1:0]   y_i,
  input  logic signed [COMPONENT_BITS-1:0]   z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               degen_o,
  output logic [COMPONENT_BITS:0]            sum_o,
  output logic [COMPONENT_BITS+1:0]          num_u_o,
  output logic [COMPONENT_BITS+1:0]          num_v_o
);
  import octenc_pkg::*;

  localparam int unsigned MagW = COMPONENT_BITS;
  localparam int unsigned SqW  = 2 * COMPONENT_BITS - 1;
  localparam int unsigned LenW = 2 * COMPONENT_BITS;
  localparam int unsigned SumW = COMPONENT_BITS + 1;
  localparam int unsigned NumW = COMPONENT_BITS + 2;
  localparam int unsigned CmpW = (LenW > CFG_W) ? LenW : CFG_W;

  // Per-stage handshake
  logic a_v_q, b_v_q, c_v_q;
  logic a_rdy, b_rdy, c_rdy;

  assign c_rdy = !c_v_q || out_ready_i;
  assign b_rdy = !b_v_q || c_rdy;
  assign a_rdy = !a_v_q || b_rdy;

  assign in_ready_o  = a_rdy;
  assign out_valid_o = c_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= in_valid_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
    end
  end

  // Stage A: squares, magnitudes and signs
  logic signed [2*COMPONENT_BITS-1:0] prod_x, prod_y, prod_z;
  logic [MagW-1:0] mag_x_d, mag_y_d, mag_z_d;
  logic [SqW-1:0]  sq_x_q, sq_y_q, sq_z_q;
  logic [MagW-1:0] mag_x_a_q, mag_y_a_q, mag_z_a_q;
  logic            neg_x_a_q, neg_y_a_q, neg_z_a_q;

  assign prod_x  = x_i * x_i;
  assign prod_y  = y_i * y_i;
  assign prod_z  = z_i * z_i;
  assign mag_x_d = x_i[COMPONENT_BITS-1] ? $unsigned(-x_i) : $unsigned(x_i);
  assign mag_y_d = y_i[COMPONENT_BITS-1] ? $unsigned(-y_i) : $unsigned(y_i);
  assign mag_z_d = z_i[COMPONENT_BITS-1] ? $unsigned(-z_i) : $unsigned(z_i);

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) begin
      sq_x_q    <= prod_x[SqW-1:0];
      sq_y_q    <= prod_y[SqW-1:0];
      sq_z_q    <= prod_z[SqW-1:0];
      mag_x_a_q <= mag_x_d;
      mag_y_a_q <= mag_y_d;
      mag_z_a_q <= mag_z_d;
      neg_x_a_q <= x_i[COMPONENT_BITS-1];
      neg_y_a_q <= y_i[COMPONENT_BITS-1];
      neg_z_a_q <= z_i[COMPONENT_BITS-1];
    end
  end

  // Stage B: squared length and L1 sum
  logic [LenW-1:0] len2_d, len2_q;
  logic [SumW-1:0] sum_b_d, sum_b_q;
  logic [MagW-1:0] mag_x_b_q, mag_y_b_q;
  logic            neg_x_b_q, neg_y_b_q, neg_z_b_q;

  assign len2_d  = LenW'(sq_x_q) + LenW'(sq_y_q) + LenW'(sq_z_q);
  assign sum_b_d = SumW'(mag_x_a_q) + SumW'(mag_y_a_q) + SumW'(mag_z_a_q);

  always_ff @(posedge clk_i) begin
    if (b_rdy && a_v_q) begin
      len2_q    <= len2_d;
      sum_b_q   <= sum_b_d;
      mag_x_b_q <= mag_x_a_q;
      mag_y_b_q <= mag_y_a_q;
      neg_x_b_q <= neg_x_a_q;
      neg_y_b_q <= neg_y_a_q;
      neg_z_b_q <= neg_z_a_q;
    end
  end

  // Stage C: threshold test and numerators over [0, 2*sum]
  logic            degen_d;
  logic [NumW-1:0] sum_n, sum2_n, ax_n, ay_n;
  logic [NumW-1:0] num_u_d, num_v_d;
  logic            degen_q;
  logic [SumW-1:0] sum_c_q;
  logic [NumW-1:0] num_u_q, num_v_q;

  assign degen_d = CmpW'(len2_q) <= CmpW'(min_len2_i);
  assign sum_n   = NumW'(sum_b_q);
  assign sum2_n  = sum_n << 1;
  assign ax_n    = NumW'(mag_x_b_q);
  assign ay_n    = NumW'(mag_y_b_q);

  always_comb begin
    if (neg_z_b_q) begin
      // fold the lower hemisphere
      num_u_d = neg_x_b_q ? ay_n : (sum2_n - ay_n);
      num_v_d = neg_y_b_q ? ax_n : (sum2_n - ax_n);
    end else begin
      num_u_d = neg_x_b_q ? (sum_n - ax_n) : (sum_n + ax_n);
      num_v_d = neg_y_b_q ? (sum_n - ay_n) : (sum_n + ay_n);
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_rdy && b_v_q) begin
      degen_q <= degen_d;
      sum_c_q <= sum_b_q;
      num_u_q <= num_u_d;
      num_v_q <= num_v_d;
    end
  end

  assign degen_o = degen_q;
  assign sum_o   = sum_c_q;
  assign num_u_o = num_u_q;
  assign num_v_o = num_v_q;

endmodule

@@ rtl/core/octenc_div.sv @@
// ----------------------------------------------------------------------------
// octenc_div
// Pipelined restoring divider, one quotient bit per stage, two lanes that
// share the divisor. Produces floor(num * 2^CODE_BITS / sum) for num in
// [0, 2*sum]: two integer bits, then CODE_BITS fraction bits.
// ----------------------------------------------------------------------------
module octenc_div #(
  parameter int unsigned COMPONENT_BITS = octenc_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned CODE_BITS      = octenc_pkg::CODE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      degen_i,
  input  logic [COMPONENT_BITS:0]   sum_i,
  input  logic [COMPONENT_BITS+1:0] num_u_i,
  input  logic [COMPONENT_BITS+1:0] num_v_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      degen_o,
  output logic [CODE_BITS+1:0]      quo_u_o,
  output logic [CODE_BITS+1:0]      quo_v_o
);
  import octenc_pkg::*;

  localparam int unsigned SumW  = COMPONENT_BITS + 1;
  localparam int unsigned NumW  = COMPONENT_BITS + 2;
  localparam int unsigned QuoW  = CODE_BITS + 2;
  localparam int unsigned Steps = QuoW;

  // Stage registers, one element per quotient bit
  logic            v_q     [Steps];
  logic            rdy     [Steps];
  logic            degen_q [Steps];
  logic [SumW-1:0] sum_q   [Steps];
  logic [NumW-1:0] rem_u_q [Steps];
  logic [NumW-1:0] rem_v_q [Steps];
  logic [QuoW-1:0] quo_u_q [Steps];
  logic [QuoW-1:0] quo_v_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int unsigned Pos = Steps - 1 - k;
    localparam bit          IntBit = (Pos >= CODE_BITS);
    localparam int unsigned Sh = IntBit ? (Pos - CODE_BITS) : 0;

    logic            v_in, degen_in, rdy_out;
    logic [SumW-1:0] sum_in;
    logic [NumW-1:0] rem_u_in, rem_v_in;
    logic [QuoW-1:0] quo_u_in, quo_v_in;
    logic [NumW-1:0] dvs, rem_u_sh, rem_v_sh, rem_u_d, rem_v_d;
    logic [QuoW-1:0] quo_u_d, quo_v_d;
    logic            ge_u, ge_v;

    // Select the upstream side
    if (k == 0) begin : g_head
      assign v_in     = in_valid_i;
      assign degen_in = degen_i;
      assign sum_in   = sum_i;
      assign rem_u_in = num_u_i;
      assign rem_v_in = num_v_i;
      assign quo_u_in = '0;
      assign quo_v_in = '0;
    end else begin : g_body
      assign v_in     = v_q[k-1];
      assign degen_in = degen_q[k-1];
      assign sum_in   = sum_q[k-1];
      assign rem_u_in = rem_u_q[k-1];
      assign rem_v_in = rem_v_q[k-1];
      assign quo_u_in = quo_u_q[k-1];
      assign quo_v_in = quo_v_q[k-1];
    end

    if (k == Steps - 1) begin : g_tail
      assign rdy_out = out_ready_i;
    end else begin : g_mid
      assign rdy_out = rdy[k+1];
    end

    assign rdy[k] = !v_q[k] || rdy_out;

    // Integer bits compare against a shifted divisor; fraction bits shift the remainder
    if (IntBit) begin : g_int
      assign dvs      = NumW'(sum_in) << Sh;
      assign rem_u_sh = rem_u_in;
      assign rem_v_sh = rem_v_in;
    end else begin : g_frac
      assign dvs      = NumW'(sum_in);
      assign rem_u_sh = rem_u_in << 1;
      assign rem_v_sh = rem_v_in << 1;
    end

    assign ge_u    = rem_u_sh >= dvs;
    assign ge_v    = rem_v_sh >= dvs;
    assign rem_u_d = ge_u ? (rem_u_sh - dvs) : rem_u_sh;
    assign rem_v_d = ge_v ? (rem_v_sh - dvs) : rem_v_sh;

    always_comb begin
      quo_u_d      = quo_u_in;
      quo_v_d      = quo_v_in;
      quo_u_d[Pos] = ge_u;
      quo_v_d[Pos] = ge_v;
    end

    // Advance valid when this stage frees up
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        degen_q[k] <= degen_in;
        sum_q[k]   <= sum_in;
        rem_u_q[k] <= rem_u_d;
        rem_v_q[k] <= rem_v_d;
        quo_u_q[k] <= quo_u_d;
        quo_v_q[k] <= quo_v_d;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[Steps-1];
  assign degen_o     = degen_q[Steps-1];
  assign quo_u_o     = quo_u_q[Steps-1];
  assign quo_v_o     = quo_v_q[Steps-1];

endmodule

@@ rtl/core/octenc_round.sv @@
// ----------------------------------------------------------------------------
// octenc_round
// Output stage: rounds the quotient half up, saturates to the code range,
// substitutes the centre code for degenerate vectors and holds the item.
// ----------------------------------------------------------------------------
module octenc_round #(
  parameter int unsigned CODE_BITS = octenc_pkg::CODE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 degen_i,
  input  logic [CODE_BITS+1:0] quo_u_i,
  input  logic [CODE_BITS+1:0] quo_v_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CODE_BITS-1:0] code_u_o,
  output logic [CODE_BITS-1:0] code_v_o,
  output logic                 degen_o
);
  import octenc_pkg::*;

  localparam int unsigned      QuoW   = CODE_BITS + 2;
  localparam logic [CODE_BITS-1:0] Center = CODE_BITS'(1) << (CODE_BITS - 1);

  logic                 v_q, rdy;
  logic [QuoW-1:0]      inc_u, inc_v;
  logic [CODE_BITS:0]   half_u, half_v;
  logic [CODE_BITS-1:0] code_u_d, code_v_d;
  logic [CODE_BITS-1:0] code_u_q, code_v_q;
  logic                 degen_q;

  assign rdy = !v_q || out_ready_i;

  // Round half up, then clamp +1.0 to the top code
  assign inc_u  = quo_u_i + QuoW'(1);
  assign inc_v  = quo_v_i + QuoW'(1);
  assign half_u = inc_u[QuoW-1:1];
  assign half_v = inc_v[QuoW-1:1];

  always_comb begin
    if (degen_i) begin
      code_u_d = Center;
      code_v_d = Center;
    end else begin
      code_u_d = half_u[CODE_BITS] ? '1 : half_u[CODE_BITS-1:0];
      code_v_d = half_v[CODE_BITS] ? '1 : half_v[CODE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  // Hold the item until taken
  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      code_u_q <= code_u_d;
      code_v_q <= code_v_d;
      degen_q  <= degen_i;
    end
  end

  assign in_ready_o  = rdy;
  assign out_valid_o = v_q;
  assign code_u_o    = code_u_q;
  assign code_v_o    = code_v_q;
  assign degen_o     = degen_q;

endmodule

@@ rtl/core/octenc_checker.sv @@
// ----------------------------------------------------------------------------
// octenc_checker
// Port-level checks for the octahedral normal encoder, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module octenc_checker #(
  parameter int unsigned COMPONENT_BITS = octenc_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned CODE_BITS      = octenc_pkg::CODE_BITS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [CODE_BITS-1:0]             encoded_u_o,
  input logic [CODE_BITS-1:0]             encoded_v_o,
  input logic                             degenerate_o
);
  import octenc_pkg::*;

  localparam logic [CODE_BITS-1:0] Center = CODE_BITS'(1) << (CODE_BITS - 1);

  // Stalled output item stays put
  `OCTENC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(encoded_u_o) && $stable(encoded_v_o) && $stable(degenerate_o), "output item changed while stalled")

  // Degenerate vectors report the centre code
  `OCTENC_ASSERT_NOW(a_degen_center, out_valid_o && degenerate_o, encoded_u_o == Center && encoded_v_o == Center, "degenerate item without centre code")

  // A free or draining output stage never blocks the input
  `OCTENC_ASSERT_NOW(a_ready_flow, !out_valid_o || out_ready_i, in_ready_o, "input blocked while output is free")

endmodule

bind octahedral_normal_encoder_unit octenc_checker #(
  .COMPONENT_BITS(COMPONENT_BITS),
  .CODE_BITS     (CODE_BITS)
) u_octenc_checker (.*);

@@ tb/octenc_code_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octenc_code_checker
// Watches the input, output and threshold ports of the octahedral normal
// encoder. It predicts the code for every accepted normal from its own copy of
// the threshold register, and compares every accepted output item with the
// oldest pending prediction, field by field.
// ----------------------------------------------------------------------------
module octenc_code_checker #(
  parameter int unsigned COMPONENT_BITS = octenc_pkg::COMPONENT_BITS_DEF,
  parameter int unsigned CODE_BITS      = octenc_pkg::CODE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [octenc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic signed [COMPONENT_BITS-1:0] normal_x_i,
  input  logic signed [COMPONENT_BITS-1:0] normal_y_i,
  input  logic signed [COMPONENT_BITS-1:0] normal_z_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [CODE_BITS-1:0]             encoded_u_i,
  input  logic [CODE_BITS-1:0]             encoded_v_i,
  input  logic                             degenerate_i,
  output int                               error_count_o,
  output int                               pending_o
);

  typedef struct packed {
    logic [CODE_BITS-1:0] u;
    logic [CODE_BITS-1:0] v;
    logic                 deg;
  } octa_code_t;

  localparam longint unsigned CODE_MAX    = (64'd1 << CODE_BITS) - 1;
  localparam longint unsigned CODE_CENTER = 64'd1 << (CODE_BITS - 1);

  octa_code_t                   pending_codes[$];
  logic [octenc_pkg::CFG_W-1:0] min_len2_q;
  int                           error_count;

  assign error_count_o = error_count;
  assign pending_o     = pending_codes.size();

  // Exact magnitude of a two's-complement component, most negative included.
  function automatic longint unsigned component_mag(input logic signed [COMPONENT_BITS-1:0] c);
    longint wide;
    wide = c;
    return (wide < 0) ? longint'(-wide) : longint'(wide);
  endfunction

  // Round n * 2^(CODE_BITS-1) / s half up and clamp to the top code.
  function automatic logic [CODE_BITS-1:0] scale_to_code(input longint unsigned n,
                                                         input longint unsigned s);
    longint unsigned q;
    q = (n << CODE_BITS) / s;
    q = (q + 1) >> 1;
    if (q > CODE_MAX) q = CODE_MAX;
    return q[CODE_BITS-1:0];
  endfunction

  // Project onto the octahedron, fold the lower hemisphere, map to codes.
  function automatic octa_code_t predict_code(input logic signed [COMPONENT_BITS-1:0] x,
                                              input logic signed [COMPONENT_BITS-1:0] y,
                                              input logic signed [COMPONENT_BITS-1:0] z,
                                              input logic [octenc_pkg::CFG_W-1:0] min_len2);
    longint unsigned ax, ay, az, len2, s, nu, nv;
    octa_code_t      code;
    ax   = component_mag(x);
    ay   = component_mag(y);
    az   = component_mag(z);
    len2 = ax * ax + ay * ay + az * az;
    if (len2 <= longint'(min_len2)) begin
      code.u   = CODE_CENTER[CODE_BITS-1:0];
      code.v   = CODE_CENTER[CODE_BITS-1:0];
      code.deg = 1'b1;
      return code;
    end
    s = ax + ay + az;
    if (z < 0) begin
      // folded: zero counts as positive
      nu = (x < 0) ? ay : (2 * s - ay);
      nv = (y < 0) ? ax : (2 * s - ax);
    end else begin
      nu = (x < 0) ? (s - ax) : (s + ax);
      nv = (y < 0) ? (s - ay) : (s + ay);
    end
    code.u   = scale_to_code(nu, s);
    code.v   = scale_to_code(nv, s);
    code.deg = 1'b0;
    return code;
  endfunction

  // Track the threshold, queue predictions, compare output items.
  always @(posedge clk_i or negedge rst_ni) begin
    octa_code_t want;
    if (!rst_ni) begin
      min_len2_q = octenc_pkg::MIN_LEN2_RST;
      pending_codes.delete();
      error_count = 0;
    end else begin
      if (cfg_we_i) min_len2_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        pending_codes.push_back(predict_code(normal_x_i, normal_y_i, normal_z_i, min_len2_q));
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_codes.size() == 0) begin
          $error("output item with no pending prediction: u %0d v %0d degenerate %0d",
                 encoded_u_i, encoded_v_i, degenerate_i);
          error_count++;
        end else begin
          want = pending_codes.pop_front();
          if (encoded_u_i !== want.u) begin
            $error("encoded_u: expected %0d, actual %0d", want.u, encoded_u_i);
            error_count++;
          end
          if (encoded_v_i !== want.v) begin
            $error("encoded_v: expected %0d, actual %0d", want.v, encoded_v_i);
            error_count++;
          end
          if (degenerate_i !== want.deg) begin
            $error("degenerate: expected %0d, actual %0d", want.deg, degenerate_i);
            error_count++;
          end
        end
      end
    end
  end

endmodule

@@ tb/octahedral_normal_encoder_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octahedral_normal_encoder_unit_test
// Drives normals into the octahedral encoder, random gaps on both sides bar two
// phases: a directed set of edge vectors first, then phases of random vectors,
// each under its own degenerate-length threshold. The checker beside the block
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module octahedral_normal_encoder_unit_test;

  localparam int unsigned CB          = octenc_pkg::COMPONENT_BITS_DEF;
  localparam int unsigned KB          = octenc_pkg::CODE_BITS_DEF;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          DRAIN_CYCLES = 60;
  localparam logic [octenc_pkg::CFG_W-1:0] MIN_LEN2_TOP = 32'd3221094400;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [octenc_pkg::CFG_W-1:0] cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic signed [CB-1:0]         normal_x_i;
  logic signed [CB-1:0]         normal_y_i;
  logic signed [CB-1:0]         normal_z_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [KB-1:0]                encoded_u_o;
  logic [KB-1:0]                encoded_v_o;
  logic                         degenerate_o;

  int   error_count;
  int   pending;
  int   cycle_count;
  int   stall_left;
  logic gaps_on;
  logic in_fire_q;

  octahedral_normal_encoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .normal_x_i  (normal_x_i),
    .normal_y_i  (normal_y_i),
    .normal_z_i  (normal_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .encoded_u_o (encoded_u_o),
    .encoded_v_o (encoded_v_o),
    .degenerate_o(degenerate_o)
  );

  octenc_code_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .normal_x_i   (normal_x_i),
    .normal_y_i   (normal_y_i),
    .normal_z_i   (normal_z_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .encoded_u_i  (encoded_u_o),
    .encoded_v_i  (encoded_v_o),
    .degenerate_i (degenerate_o),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Record input acceptance so the driver can see it at the next falling edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire_q <= 1'b0;
    end else begin
      in_fire_q <= in_valid_i && in_ready_o;
    end
  end

  // Hard stop on a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the output side at random.
  always @(negedge clk_i) begin
    if (!gaps_on) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  function automatic int signed_in_range(input int mag);
    return $urandom_range(0, 2 * mag) - mag;
  endfunction

  // Pick a random normal from a mix of shapes.
  task automatic make_normal(output logic signed [CB-1:0] x,
                             output logic signed [CB-1:0] y,
                             output logic signed [CB-1:0] z);
    int kind;
    int axis;
    int big;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      // full-width random bits, most negative value included
      x = CB'($urandom);
      y = CB'($urandom);
      z = CB'($urandom);
    end else if (kind < 55) begin
      // one dominant axis, like a unit normal
      axis = $urandom_range(0, 2);
      big  = $urandom_range(20000, 32767) * ($urandom_range(0, 1) ? 1 : -1);
      x = CB'(signed_in_range(12000));
      y = CB'(signed_in_range(12000));
      z = CB'(signed_in_range(12000));
      case (axis)
        0: x = CB'(big);
        1: y = CB'(big);
        default: z = CB'(big);
      endcase
    end else if (kind < 70) begin
      // short vectors around the threshold
      x = CB'(signed_in_range(20));
      y = CB'(signed_in_range(20));
      z = CB'(signed_in_range(20));
    end else if (kind < 85) begin
      // zero components, which take the positive sign in the fold
      x = ($urandom_range(0, 1)) ? CB'(0) : CB'(signed_in_range(32767));
      y = ($urandom_range(0, 1)) ? CB'(0) : CB'(signed_in_range(32767));
      z = ($urandom_range(0, 2) == 0) ? CB'(0) : CB'(signed_in_range(32767));
    end else begin
      // lower hemisphere or z = 0, near the fold seam, |x| close to |y|
      big = $urandom_range(1, 32767);
      x = CB'(($urandom_range(0, 1) ? big : -big));
      y = CB'(($urandom_range(0, 1) ? big : -big) + signed_in_range(3));
      z = CB'(-$urandom_range(0, 32767));
    end
  endtask

  // Present one normal and hold it until accepted.
  task automatic send_normal(input logic signed [CB-1:0] x,
                             input logic signed [CB-1:0] y,
                             input logic signed [CB-1:0] z);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    normal_x_i <= x;
    normal_y_i <= y;
    normal_z_i <= z;
    do @(negedge clk_i); while (!in_fire_q);
  endtask

  // Drop valid and wait until every predicted code has come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [octenc_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [octenc_pkg::CFG_W-1:0] threshold,
                                  input int count, input logic with_gaps);
    logic signed [CB-1:0] x, y, z;
    write_threshold(threshold);
    gaps_on = with_gaps;
    repeat (count) begin
      make_normal(x, y, z);
      send_normal(x, y, z);
    end
    gaps_on = 1'b1;
  endtask

  // Stimulus and verdict.
  initial begin
    cycle_count = 0;
    stall_left  = 0;
    gaps_on     = 1'b1;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    normal_x_i  = '0;
    normal_y_i  = '0;
    normal_z_i  = '0;
    out_ready_i = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed edge vectors under the reset threshold.
    send_normal(16'sd0, 16'sd0, 16'sd0);
    send_normal(16'sd32767, 16'sd0, 16'sd0);
    send_normal(-16'sd32767, 16'sd0, 16'sd0);
    send_normal(16'sd0, 16'sd32767, 16'sd0);
    send_normal(16'sd0, -16'sd32767, 16'sd0);
    send_normal(16'sd0, 16'sd0, 16'sd32767);
    send_normal(16'sd0, 16'sd0, -16'sd32767);
    send_normal(-16'sd32768, 16'sd0, 16'sd0);
    send_normal(16'sd0, 16'sd0, -16'sd32768);
    send_normal(-16'sd32768, -16'sd32768, -16'sd32768);
    send_normal(16'sd32767, 16'sd32767, 16'sd32767);
    send_normal(16'sd32767, -16'sd32768, -16'sd32767);
    send_normal(16'sd0, 16'sd100, -16'sd100);
    send_normal(16'sd100, 16'sd0, -16'sd100);
    send_normal(16'sd0, 16'sd0, -16'sd200);
    send_normal(-16'sd150, -16'sd150, -16'sd1);
    send_normal(16'sd7, 16'sd7, 16'sd3);
    send_normal(16'sd7, 16'sd7, 16'sd4);
    send_normal(-16'sd7, 16'sd7, -16'sd3);
    send_normal(-16'sd11, 16'sd5, -16'sd9);
    send_normal(16'sd12345, -16'sd23456, -16'sd3210);
    send_normal(16'sd1, 16'sd1, 16'sd1);

    // Random phases, each under its own threshold.
    run_random_phase('0, 200, 1'b1);
    run_random_phase(MIN_LEN2_TOP, 120, 1'b1);
    run_random_phase($urandom_range(0, 2000), 250, 1'b0);
    run_random_phase(octenc_pkg::MIN_LEN2_RST, 300, 1'b1);
    run_random_phase($urandom_range(0, MIN_LEN2_TOP), 130, 1'b1);
    run_random_phase($urandom_range(1000, 4000000), 250, 1'b1);
    run_random_phase('0, 200, 1'b0);

    // Drain and watch for stray output items.
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
